// ----- rtl/dvrt_pkg.sv -----
`timescale 1ns / 1ps

package dvrt_pkg;

	// request kinds carried in the low bits of the request
	typedef enum logic [1:0] {
		REQ_INIT   = 2'd0,
		REQ_SET    = 2'd1,
		REQ_MERGE  = 2'd2,
		REQ_LOOKUP = 2'd3
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_BCAST     = 2'd2
	} status_t;

	// table update controls from the evaluator to the table
	typedef struct packed {
		logic write;
		logic clear;
	} tbl_ctl_t;

	// configuration register word index
	localparam logic REG_OWN_ADDRESS = 1'b0;

	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_ADDR_BITS = 3;

endpackage

// ----- rtl/dvrt_cfg.sv -----
`timescale 1ns / 1ps

module dvrt_cfg #(
	parameter int ADDRESS_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dvrt_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [dvrt_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [dvrt_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	output logic [ADDRESS_BITS-1:0]             own_address
);

	logic [ADDRESS_BITS-1:0] own_address_q;
	logic                    sel_own;
	logic                    wr_stb;

	// word decode: bit 2 picks the register word
	assign sel_own = (paddr[2] == dvrt_pkg::REG_OWN_ADDRESS);
	assign pready  = 1'b1;
	assign wr_stb  = psel & penable & pwrite & pready;

	// own address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
		end else if (wr_stb && sel_own) begin
			own_address_q <= pwdata[ADDRESS_BITS-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (sel_own) begin
			prdata = {{(dvrt_pkg::CFG_DATA_BITS-ADDRESS_BITS){1'b0}}, own_address_q};
		end
	end

	assign own_address = own_address_q;

endmodule

// ----- rtl/dvrt_mem.sv -----
`timescale 1ns / 1ps

module dvrt_mem #(
	parameter int ADDRESS_BITS = 8,
	parameter int COST_BITS    = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  logic [ADDRESS_BITS-1:0] rd_addr,
	output logic [ADDRESS_BITS-1:0] rd_hop,
	output logic [COST_BITS-1:0]    rd_cost,
	input  logic [ADDRESS_BITS-1:0] vld_addr,
	output logic                    vld,
	input  dvrt_pkg::tbl_ctl_t      ctl,
	input  logic [ADDRESS_BITS-1:0] wr_addr,
	input  logic [ADDRESS_BITS-1:0] wr_hop,
	input  logic [COST_BITS-1:0]    wr_cost
);

	localparam int DEPTH  = 1 << ADDRESS_BITS;
	localparam int WORD_W = ADDRESS_BITS + COST_BITS;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [DEPTH-1:0]  valid_q;

	// entry storage, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (ctl.write) begin
			mem[wr_addr] <= {wr_hop, wr_cost};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_hop  = rd_data_q[WORD_W-1:COST_BITS];
	assign rd_cost = rd_data_q[COST_BITS-1:0];

	// per-entry valid flags, cleared together on init, the written entry set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < DEPTH; i++) begin
				valid_q[i] <= (ctl.write && (wr_addr == ADDRESS_BITS'(i))) ||
					(!ctl.clear && valid_q[i]);
			end
		end
	end

	assign vld = valid_q[vld_addr];

endmodule

// ----- rtl/dvrt_eval.sv -----
`timescale 1ns / 1ps

module dvrt_eval #(
	parameter int ADDRESS_BITS = 8,
	parameter int COST_BITS    = 8
) (
	input  dvrt_pkg::req_t          req_type,
	input  logic [ADDRESS_BITS-1:0] destination,
	input  logic [ADDRESS_BITS-1:0] set_hop,
	input  logic [COST_BITS-1:0]    cost,
	input  logic [ADDRESS_BITS-1:0] neighbor_address,
	input  logic [ADDRESS_BITS-1:0] own_address,
	input  logic                    ent_valid,
	input  logic [ADDRESS_BITS-1:0] ent_hop,
	input  logic [COST_BITS-1:0]    ent_cost,
	output dvrt_pkg::tbl_ctl_t      ctl,
	output logic [ADDRESS_BITS-1:0] wr_addr,
	output logic [ADDRESS_BITS-1:0] wr_hop,
	output logic [COST_BITS-1:0]    wr_cost,
	output logic [ADDRESS_BITS-1:0] res_hop,
	output logic [COST_BITS-1:0]    res_cost,
	output logic                    res_changed,
	output dvrt_pkg::status_t       res_status
);

	localparam logic [ADDRESS_BITS-1:0] BCAST    = '1;
	localparam logic [COST_BITS-1:0]    COST_MAX = '1;

	logic [COST_BITS-1:0] relaxed_cost;
	logic                 take_merge;

	// advertised cost plus one hop, saturating
	assign relaxed_cost = (cost == COST_MAX) ? COST_MAX : cost + COST_BITS'(1);
	assign take_merge   = !ent_valid || (relaxed_cost < ent_cost);

	// per request kind: table update and result
	always_comb begin
		ctl         = '0;
		wr_addr     = destination;
		wr_hop      = set_hop;
		wr_cost     = cost;
		res_hop     = BCAST;
		res_cost    = '0;
		res_changed = 1'b0;
		res_status  = dvrt_pkg::ST_OK;
		case (req_type)
			dvrt_pkg::REQ_INIT: begin
				ctl.clear = 1'b1;
				wr_addr   = own_address;
				wr_hop    = BCAST;
				wr_cost   = '0;
				if (own_address == BCAST) begin
					res_status = dvrt_pkg::ST_BCAST;
				end else begin
					ctl.write   = 1'b1;
					res_changed = 1'b1;
				end
			end
			dvrt_pkg::REQ_SET: begin
				ctl.write   = 1'b1;
				res_hop     = set_hop;
				res_cost    = cost;
				res_changed = 1'b1;
			end
			dvrt_pkg::REQ_MERGE: begin
				wr_hop  = neighbor_address;
				wr_cost = relaxed_cost;
				if (take_merge) begin
					ctl.write   = 1'b1;
					res_hop     = neighbor_address;
					res_cost    = relaxed_cost;
					res_changed = 1'b1;
				end else begin
					res_hop  = ent_hop;
					res_cost = ent_cost;
				end
			end
			dvrt_pkg::REQ_LOOKUP: begin
				if (destination == BCAST) begin
					res_status = dvrt_pkg::ST_BCAST;
				end else if (!ent_valid) begin
					res_status = dvrt_pkg::ST_NOT_FOUND;
				end else begin
					res_hop  = ent_hop;
					res_cost = ent_cost;
				end
			end
			default: begin
				res_status = dvrt_pkg::ST_OK;
			end
		endcase
	end

endmodule

// ----- rtl/distance_vector_route_table.sv -----
// Pipeline: an accepted request is registered in stage 1 with the entry memory read,
// then in the result register once it is free. Throughput: one request per cycle
// unless m_axis_tready stalls the results; the single write port of the entry memory,
// with write-to-read forwarding of the previous update, sets that figure.
// Reset: arst_n clears all entry valid flags, the own address and the pipeline
// valid flags at once; no clearing pass, requests are taken right after reset.
`timescale 1ns / 1ps

module distance_vector_route_table #(
	parameter int ADDRESS_BITS = 8,
	parameter int COST_BITS    = 8
) (
	input  logic clk,
	input  logic arst_n,
	// config port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dvrt_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [dvrt_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [dvrt_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	// request stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// req_type, destination, set_hop, cost, neighbor_address, zero pad
	input  logic [((2+3*ADDRESS_BITS+COST_BITS+7)/8)*8-1:0] s_axis_tdata,
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// result_next_hop, result_cost, route_changed, status, zero pad
	output logic [((ADDRESS_BITS+COST_BITS+3+7)/8)*8-1:0]   m_axis_tdata
);

	localparam int OUT_RAW = ADDRESS_BITS + COST_BITS + 3;
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
	localparam int DST_LO  = 2;
	localparam int HOP_LO  = DST_LO + ADDRESS_BITS;
	localparam int CST_LO  = HOP_LO + ADDRESS_BITS;
	localparam int NBR_LO  = CST_LO + COST_BITS;

	logic [ADDRESS_BITS-1:0] own_address;

	// request fields at the input
	dvrt_pkg::req_t          in_req;
	logic [ADDRESS_BITS-1:0] in_dst;
	logic [ADDRESS_BITS-1:0] in_hop;
	logic [COST_BITS-1:0]    in_cost;
	logic [ADDRESS_BITS-1:0] in_nbr;

	// stage 1 registers
	logic                    vld_s1;
	dvrt_pkg::req_t          req_s1;
	logic [ADDRESS_BITS-1:0] dst_s1;
	logic [ADDRESS_BITS-1:0] hop_s1;
	logic [COST_BITS-1:0]    cost_s1;
	logic [ADDRESS_BITS-1:0] nbr_s1;
	logic                    byp_hit_s1;
	logic [ADDRESS_BITS-1:0] byp_hop_s1;
	logic [COST_BITS-1:0]    byp_cost_s1;

	// result register
	logic                    out_valid_q;
	logic [ADDRESS_BITS-1:0] out_hop_q;
	logic [COST_BITS-1:0]    out_cost_q;
	logic                    out_changed_q;
	dvrt_pkg::status_t       out_status_q;

	logic                    accept;
	logic                    adv_s1;
	logic                    out_free;

	logic [ADDRESS_BITS-1:0] mem_hop;
	logic [COST_BITS-1:0]    mem_cost;
	logic                    ent_valid;
	logic [ADDRESS_BITS-1:0] ent_hop;
	logic [COST_BITS-1:0]    ent_cost;

	dvrt_pkg::tbl_ctl_t      ev_ctl;
	dvrt_pkg::tbl_ctl_t      mem_ctl;
	logic [ADDRESS_BITS-1:0] wr_addr;
	logic [ADDRESS_BITS-1:0] wr_hop;
	logic [COST_BITS-1:0]    wr_cost;
	logic [ADDRESS_BITS-1:0] res_hop;
	logic [COST_BITS-1:0]    res_cost;
	logic                    res_changed;
	dvrt_pkg::status_t       res_status;

	dvrt_cfg #(
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.own_address(own_address)
	);

	// unpack the request
	assign in_req  = dvrt_pkg::req_t'(s_axis_tdata[1:0]);
	assign in_dst  = s_axis_tdata[DST_LO +: ADDRESS_BITS];
	assign in_hop  = s_axis_tdata[HOP_LO +: ADDRESS_BITS];
	assign in_cost = s_axis_tdata[CST_LO +: COST_BITS];
	assign in_nbr  = s_axis_tdata[NBR_LO +: ADDRESS_BITS];

	// handshake: stage 1 moves when the result register is free or drains
	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv_s1        = vld_s1 && out_free;
	assign s_axis_tready = !vld_s1 || out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// table writes only when stage 1 hands its result on
	assign mem_ctl.write = ev_ctl.write && adv_s1;
	assign mem_ctl.clear = ev_ctl.clear && adv_s1;

	dvrt_mem #(
		.ADDRESS_BITS(ADDRESS_BITS),
		.COST_BITS   (COST_BITS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_dst),
		.rd_hop  (mem_hop),
		.rd_cost (mem_cost),
		.vld_addr(dst_s1),
		.vld     (ent_valid),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_hop  (wr_hop),
		.wr_cost (wr_cost)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	// stage 1 payload and forwarding of the update written at the same edge
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= in_req;
			dst_s1      <= in_dst;
			hop_s1      <= in_hop;
			cost_s1     <= in_cost;
			nbr_s1      <= in_nbr;
			byp_hit_s1  <= mem_ctl.write && (wr_addr == in_dst);
			byp_hop_s1  <= wr_hop;
			byp_cost_s1 <= wr_cost;
		end
	end

	assign ent_hop  = byp_hit_s1 ? byp_hop_s1 : mem_hop;
	assign ent_cost = byp_hit_s1 ? byp_cost_s1 : mem_cost;

	dvrt_eval #(
		.ADDRESS_BITS(ADDRESS_BITS),
		.COST_BITS   (COST_BITS)
	) u_eval (
		.req_type        (req_s1),
		.destination     (dst_s1),
		.set_hop         (hop_s1),
		.cost            (cost_s1),
		.neighbor_address(nbr_s1),
		.own_address     (own_address),
		.ent_valid       (ent_valid),
		.ent_hop         (ent_hop),
		.ent_cost        (ent_cost),
		.ctl             (ev_ctl),
		.wr_addr         (wr_addr),
		.wr_hop          (wr_hop),
		.wr_cost         (wr_cost),
		.res_hop         (res_hop),
		.res_cost        (res_cost),
		.res_changed     (res_changed),
		.res_status      (res_status)
	);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= vld_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_hop_q     <= res_hop;
			out_cost_q    <= res_cost;
			out_changed_q <= res_changed;
			out_status_q  <= res_status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W-OUT_RAW){1'b0}}, out_status_q, out_changed_q,
		out_cost_q, out_hop_q};

endmodule
